[hw/rtl/jsu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and a hex decoder for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

   typedef logic [7:0] byte_type;

   // one result transaction
   typedef struct packed {
      byte_type out_byte;
      logic     byte_valid;
      logic     string_end;
      logic     bad_escape;
   } rsp_item_type;

   localparam int unsigned MAX_RESULTS = 3;

   localparam byte_type CH_QUOTE     = 8'h22;
   localparam byte_type CH_BACKSLASH = 8'h5c;
   localparam byte_type CH_SLASH     = 8'h2f;
   localparam byte_type CH_B         = 8'h62;
   localparam byte_type CH_F         = 8'h66;
   localparam byte_type CH_N         = 8'h6e;
   localparam byte_type CH_R         = 8'h72;
   localparam byte_type CH_T         = 8'h74;
   localparam byte_type CH_U         = 8'h75;

   localparam byte_type CTL_BS  = 8'h08;
   localparam byte_type CTL_FF  = 8'h0c;
   localparam byte_type CTL_LF  = 8'h0a;
   localparam byte_type CTL_CR  = 8'h0d;
   localparam byte_type CTL_TAB = 8'h09;

   // top five bits of a utf-16 surrogate unit
   localparam logic [4:0] SURR_PREFIX = 5'b11011;

   localparam byte_type UTF8_LEAD2 = 8'hc0;
   localparam byte_type UTF8_LEAD3 = 8'he0;
   localparam byte_type UTF8_CONT  = 8'h80;

   // returns {is_hex, value}
   function automatic logic [4:0] hex_decode(input byte_type c);
      byte_type d_num;
      byte_type d_low;
      byte_type d_up;
      logic [4:0] res;
      d_num = c - 8'h30;
      d_low = c - 8'h57;
      d_up  = c - 8'h37;
      if (c >= 8'h30 && c <= 8'h39) begin
         res = {1'b1, d_num[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         res = {1'b1, d_low[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         res = {1'b1, d_up[3:0]};
      end else begin
         res = 5'd0;
      end
      return res;
   endfunction

endpackage

[hw/rtl/jsu_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_if
// Valid/ready channels carrying raw input bytes and unescaped results.
// ----------------------------------------------------------------------------
interface jsu_req_if;
   logic              valid;
   logic              ready;
   jsu_pkg::byte_type in_byte;
   logic              is_last;

   modport source (output valid, output in_byte, output is_last, input ready);
   modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

interface jsu_rsp_if;
   logic              valid;
   logic              ready;
   jsu_pkg::byte_type out_byte;
   logic              byte_valid;
   logic              string_end;
   logic              bad_escape;

   modport source (output valid, output out_byte, output byte_valid,
                   output string_end, output bad_escape, input ready);
   modport sink (input valid, input out_byte, input byte_valid,
                 input string_end, input bad_escape, output ready);
endinterface

[hw/rtl/json_string_unescape.sv]
`timescale 1ns / 1ps
// The first result of a byte is offered in the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte gives at most one result and
// results are taken; a byte with more results holds the input until only its
// last is left, as the 3-entry buffer drains one result per cycle on one output port.
// Reset: synchronous, active high; clears escape state, drop flag and the buffer.
// ----------------------------------------------------------------------------
// json_string_unescape
// Unescapes a JSON string body one byte per transaction, expanding \u escapes
// to UTF-8 and flagging malformed \u escapes with a single error result.
// ----------------------------------------------------------------------------
module json_string_unescape (
   input  logic            clock,
   input  logic            reset,
   jsu_req_if.sink         req_chan,
   jsu_rsp_if.source       rsp_chan
);

   typedef enum logic [2:0] {
      PH_TEXT = 3'd0,
      PH_ESC  = 3'd1,
      PH_HEX0 = 3'd2,
      PH_HEX1 = 3'd3,
      PH_HEX2 = 3'd4,
      PH_HEX3 = 3'd5
   } phase_type;

   phase_type                phase_ff, phase_in;
   logic [11:0]              accum_ff, accum_in;
   logic                     drop_ff, drop_in;
   jsu_pkg::rsp_item_type    buf_ff [jsu_pkg::MAX_RESULTS];
   jsu_pkg::rsp_item_type    buf_in [jsu_pkg::MAX_RESULTS];
   logic [1:0]               cnt_ff, cnt_in;

   jsu_pkg::rsp_item_type    res [jsu_pkg::MAX_RESULTS];
   logic [1:0]               res_n;
   logic                     req_fire;
   logic                     rsp_fire;
   logic [4:0]               hex;
   logic [15:0]              unit;
   jsu_pkg::byte_type        c;
   logic                     last;

   assign req_chan.ready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = (cnt_ff != 2'd0);
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;

   assign rsp_chan.out_byte   = buf_ff[0].out_byte;
   assign rsp_chan.byte_valid = buf_ff[0].byte_valid;
   assign rsp_chan.string_end = buf_ff[0].string_end;
   assign rsp_chan.bad_escape = buf_ff[0].bad_escape;

   assign c    = req_chan.in_byte;
   assign last = req_chan.is_last;
   assign hex  = jsu_pkg::hex_decode(c);
   assign unit = {accum_ff, hex[3:0]};

   // per-byte decode: next state and up to three results
   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      drop_in  = drop_ff;
      res_n    = 2'd0;
      for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++) begin
         res[i] = '0;
      end

      if (drop_ff) begin
         if (last) begin
            drop_in  = 1'b0;
            phase_in = PH_TEXT;
            accum_in = 12'd0;
         end
      end else begin
         unique case (phase_ff)
            PH_ESC: begin
               phase_in = PH_TEXT;
               res_n    = 2'd1;
               res[0]   = '{out_byte: c, byte_valid: 1'b1, string_end: last,
                            bad_escape: 1'b0};
               unique case (c)
                  jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH: begin
                  end
                  jsu_pkg::CH_B: res[0].out_byte = jsu_pkg::CTL_BS;
                  jsu_pkg::CH_F: res[0].out_byte = jsu_pkg::CTL_FF;
                  jsu_pkg::CH_N: res[0].out_byte = jsu_pkg::CTL_LF;
                  jsu_pkg::CH_R: res[0].out_byte = jsu_pkg::CTL_CR;
                  jsu_pkg::CH_T: res[0].out_byte = jsu_pkg::CTL_TAB;
                  jsu_pkg::CH_U: begin
                     if (last) begin
                        res[0] = '{out_byte: 8'd0, byte_valid: 1'b0,
                                   string_end: 1'b1, bad_escape: 1'b1};
                        accum_in = 12'd0;
                     end else begin
                        res_n    = 2'd0;
                        phase_in = PH_HEX0;
                        accum_in = 12'd0;
                     end
                  end
                  default: begin
                     // unknown escape goes out literally as two bytes
                     res_n  = 2'd2;
                     res[0] = '{out_byte: jsu_pkg::CH_BACKSLASH, byte_valid: 1'b1,
                                string_end: 1'b0, bad_escape: 1'b0};
                     res[1] = '{out_byte: c, byte_valid: 1'b1, string_end: last,
                                bad_escape: 1'b0};
                  end
               endcase
            end
            PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
               if (!hex[4] || (phase_ff != PH_HEX3 && last) ||
                   (phase_ff == PH_HEX3 && unit[15:11] == jsu_pkg::SURR_PREFIX)) begin
                  // bad, short or surrogate unit ends the string with an error
                  phase_in = PH_TEXT;
                  accum_in = 12'd0;
                  drop_in  = !last;
                  res_n    = 2'd1;
                  res[0]   = '{out_byte: 8'd0, byte_valid: 1'b0, string_end: 1'b1,
                               bad_escape: 1'b1};
               end else if (phase_ff != PH_HEX3) begin
                  accum_in = {accum_ff[7:0], hex[3:0]};
                  unique case (phase_ff)
                     PH_HEX0: phase_in = PH_HEX1;
                     PH_HEX1: phase_in = PH_HEX2;
                     default: phase_in = PH_HEX3;
                  endcase
               end else begin
                  phase_in = PH_TEXT;
                  accum_in = 12'd0;
                  if (unit[15:7] == 9'd0) begin
                     res_n  = 2'd1;
                     res[0] = '{out_byte: unit[7:0], byte_valid: 1'b1,
                                string_end: last, bad_escape: 1'b0};
                  end else if (unit[15:11] == 5'd0) begin
                     res_n  = 2'd2;
                     res[0] = '{out_byte: jsu_pkg::UTF8_LEAD2 | {3'd0, unit[10:6]},
                                byte_valid: 1'b1, string_end: 1'b0, bad_escape: 1'b0};
                     res[1] = '{out_byte: jsu_pkg::UTF8_CONT | {2'd0, unit[5:0]},
                                byte_valid: 1'b1, string_end: last, bad_escape: 1'b0};
                  end else begin
                     res_n  = 2'd3;
                     res[0] = '{out_byte: jsu_pkg::UTF8_LEAD3 | {4'd0, unit[15:12]},
                                byte_valid: 1'b1, string_end: 1'b0, bad_escape: 1'b0};
                     res[1] = '{out_byte: jsu_pkg::UTF8_CONT | {2'd0, unit[11:6]},
                                byte_valid: 1'b1, string_end: 1'b0, bad_escape: 1'b0};
                     res[2] = '{out_byte: jsu_pkg::UTF8_CONT | {2'd0, unit[5:0]},
                                byte_valid: 1'b1, string_end: last, bad_escape: 1'b0};
                  end
               end
            end
            default: begin
               phase_in = PH_TEXT;
               accum_in = 12'd0;
               if (c == jsu_pkg::CH_BACKSLASH && !last) begin
                  phase_in = PH_ESC;
               end else begin
                  res_n  = 2'd1;
                  res[0] = '{out_byte: c, byte_valid: 1'b1, string_end: last,
                             bad_escape: 1'b0};
               end
            end
         endcase
      end
   end

   // result buffer: load on a new transaction, else shift out on a pop
   always_comb begin
      cnt_in = cnt_ff;
      for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++) begin
         buf_in[i] = buf_ff[i];
      end
      if (req_fire) begin
         cnt_in = res_n;
         for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++) begin
            buf_in[i] = res[i];
         end
      end else if (rsp_fire) begin
         cnt_in    = cnt_ff - 2'd1;
         buf_in[0] = buf_ff[1];
         buf_in[1] = buf_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++) begin
         buf_ff[i] <= buf_in[i];
      end
      if (reset) begin
         cnt_ff   <= 2'd0;
         phase_ff <= PH_TEXT;
         accum_ff <= 12'd0;
         drop_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (req_fire) begin
            phase_ff <= phase_in;
            accum_ff <= accum_in;
            drop_ff  <= drop_in;
         end
      end
   end

`ifndef SYNTH
   a_no_accept_with_backlog: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && rsp_fire)))
      else $error("transaction accepted while older results were still buffered");

   a_error_result_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.bad_escape) |->
         (rsp_chan.string_end && !rsp_chan.byte_valid && rsp_chan.out_byte == 8'd0))
      else $error("error result without end of string or with data");

   a_drop_after_error: assert property (@(posedge clock) disable iff (reset)
      $rose(drop_ff) |-> ($past(req_fire) && rsp_chan.valid && rsp_chan.bad_escape))
      else $error("drop mode entered without an error result");

   a_drop_in_text: assert property (@(posedge clock) disable iff (reset)
      drop_ff |-> (phase_ff == PH_TEXT && accum_ff == 12'd0))
      else $error("escape state left over while dropping input");
`endif

endmodule
